// ===== rtl/dfhe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dfhe_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int Q_DEPTH = 2;
    localparam int NUM_LEN_CODES = 29;
    localparam int NUM_DIST_CODES = 30;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_LITERAL = 2'd1;
    localparam logic [1:0] KIND_MATCH   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [8:0] SYM_END_OF_BLOCK = 9'd256;
    localparam logic [8:0] SYM_LEN_FIRST    = 9'd257;
    localparam logic [8:0] LEN_MIN          = 9'd3;
    localparam logic [8:0] LEN_MAX          = 9'd258;
    localparam logic [15:0] DIST_MAX        = 16'd32768;
    localparam logic [3:0] DIST_CODE_WIDTH  = 4'd5;

    localparam logic [8:0] LEN_BASE [NUM_LEN_CODES] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
        9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
        9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258};
    localparam logic [2:0] LEN_EXTRA [NUM_LEN_CODES] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd0};
    localparam logic [15:0] DIST_BASE [NUM_DIST_CODES] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
        16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385, 16'd513,
        16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097, 16'd6145,
        16'd8193, 16'd12289, 16'd16385, 16'd24577};
    localparam logic [3:0] DIST_EXTRA [NUM_DIST_CODES] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13};

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  literal;
        logic [8:0]  match_length;
        logic [15:0] match_distance;
    } t_in_item;

    typedef struct packed {
        logic [12:0] code_bits;
        logic [3:0]  code_width;
        logic        code_word;
        logic        flush_request;
        logic        bad_token;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [12:0] bits;
        logic [3:0]  width;
        logic        word;
        logic        flush;
        logic        bad;
    } t_field;

    typedef struct packed {
        t_field [NUM_SLOTS-1:0] fields;
        logic [1:0]             last_idx;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_field fixed_ll(input logic [8:0] sym);
        t_field r;
        r = '0;
        r.word = 1'b1;
        if (sym <= 9'd143) begin
            r.bits  = 13'(sym) + 13'h30;
            r.width = 4'd8;
        end else if (sym <= 9'd255) begin
            r.bits  = 13'(sym) + 13'h100;
            r.width = 4'd9;
        end else if (sym <= 9'd279) begin
            r.bits  = 13'(sym[7:0]);
            r.width = 4'd7;
        end else begin
            r.bits  = 13'(sym) - 13'h58;
            r.width = 4'd8;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/dfhe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dfhe_front (
    input  var dfhe_pkg::t_in_item i_item,
    output dfhe_pkg::t_cmd         o_cmd
);
    import dfhe_pkg::*;

    logic [4:0]  li;
    logic [4:0]  di;
    logic        bad;
    logic        has_le;
    logic        has_de;
    t_field      f_lcode;
    t_field      f_lextra;
    t_field      f_dcode;
    t_field      f_dextra;
    logic [8:0]  len_off;
    logic [15:0] dist_off;

    always_comb begin
        li = '0;
        for (int i = 0; i < NUM_LEN_CODES; i++) begin
            if (i_item.match_length >= LEN_BASE[i]) li = 5'(i);
        end
        di = '0;
        for (int i = 0; i < NUM_DIST_CODES; i++) begin
            if (i_item.match_distance >= DIST_BASE[i]) di = 5'(i);
        end
    end

    always_comb begin
        bad = (i_item.match_length < LEN_MIN) || (i_item.match_length > LEN_MAX)
            || (i_item.match_distance == 16'd0) || (i_item.match_distance > DIST_MAX);
        has_le   = LEN_EXTRA[li] != 3'd0;
        has_de   = DIST_EXTRA[di] != 4'd0;
        len_off  = i_item.match_length - LEN_BASE[li];
        dist_off = i_item.match_distance - DIST_BASE[di];

        f_lcode  = fixed_ll(SYM_LEN_FIRST + 9'(li));
        f_lextra = '0;
        f_lextra.bits  = 13'(len_off);
        f_lextra.width = 4'(LEN_EXTRA[li]);
        f_dcode = '0;
        f_dcode.bits  = 13'(di);
        f_dcode.width = DIST_CODE_WIDTH;
        f_dcode.word  = 1'b1;
        f_dextra = '0;
        f_dextra.bits  = dist_off[12:0];
        f_dextra.width = DIST_EXTRA[di];
    end

    always_comb begin
        o_cmd = '0;
        case (i_item.kind)
            KIND_START: begin
                o_cmd.fields[0].bits  = 13'd1;
                o_cmd.fields[0].width = 4'd1;
                o_cmd.fields[1].bits  = 13'd1;
                o_cmd.fields[1].width = 4'd2;
                o_cmd.last_idx = 2'd1;
            end
            KIND_LITERAL: begin
                o_cmd.fields[0] = fixed_ll({1'b0, i_item.literal});
                o_cmd.last_idx = 2'd0;
            end
            KIND_END: begin
                o_cmd.fields[0] = fixed_ll(SYM_END_OF_BLOCK);
                o_cmd.fields[0].flush = 1'b1;
                o_cmd.last_idx = 2'd0;
            end
            KIND_MATCH: begin
                if (bad) begin
                    o_cmd.fields[0].bad = 1'b1;
                    o_cmd.last_idx = 2'd0;
                end else begin
                    o_cmd.fields[0] = f_lcode;
                    o_cmd.fields[1] = has_le ? f_lextra : f_dcode;
                    o_cmd.fields[2] = has_le ? f_dcode : f_dextra;
                    o_cmd.fields[3] = f_dextra;
                    o_cmd.last_idx = 2'd1 + 2'(has_le) + 2'(has_de);
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dfhe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dfhe_queue (
    input  var logic            i_clk,
    input  var logic            i_rst_n,
    input  var dfhe_pkg::t_q_req i_req,
    input  var dfhe_pkg::t_cmd   i_cmd,
    output dfhe_pkg::t_q_stat    o_stat,
    output dfhe_pkg::t_cmd       o_cmd
);
    import dfhe_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = r_count == (PTR_W+1)'(Q_DEPTH);
    assign o_stat.empty = r_count == '0;
    assign do_push = i_req.push && !o_stat.full;
    assign do_pop  = i_req.pop && !o_stat.empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (do_pop)  r_rd <= (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_count <= r_count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(Q_DEPTH))
        else $error("queue count over depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.pop |-> !o_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/dfhe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dfhe_back (
    input  var logic             i_clk,
    input  var logic             i_rst_n,
    input  var dfhe_pkg::t_q_stat i_stat,
    input  var dfhe_pkg::t_cmd    i_cmd,
    input  var logic             i_pop,
    output logic                 o_q_pop,
    output logic                 o_valid,
    output dfhe_pkg::t_out_item  o_result
);
    import dfhe_pkg::*;

    t_cmd      r_cmd;
    logic      r_have;
    logic [1:0] r_idx;
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_free;
    logic      emit;
    logic      at_last;
    t_field    cur;

    assign out_free = !r_out_valid || i_pop;
    assign emit     = r_have && out_free;
    assign at_last  = r_idx == r_cmd.last_idx;
    assign cur      = r_cmd.fields[r_idx];
    assign o_q_pop  = !i_stat.empty && (!r_have || (emit && at_last));
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cmd <= i_cmd;
        if (emit) begin
            r_out.code_bits     <= cur.bits;
            r_out.code_width    <= cur.width;
            r_out.code_word     <= cur.word;
            r_out.flush_request <= cur.flush;
            r_out.bad_token     <= cur.bad;
            r_out.last_of_run   <= at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop) begin
                r_have <= 1'b1;
                r_idx  <= '0;
            end else if (emit) begin
                if (at_last) begin
                    r_have <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_idx <= r_cmd.last_idx))
        else $error("slot index past last field");
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.bad_token) |-> (r_out.last_of_run && r_out.code_width == 4'd0))
        else $error("error result not alone");
    a_width_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.bad_token) |-> (r_out.code_width != 4'd0))
        else $error("empty bit field emitted");
`endif

endmodule
`default_nettype wire

// ===== rtl/deflate_fixed_huffman_encoder.sv =====
// path: the first result of a token passes the command queue, the command register and the output register
// throughput: one result per cycle while the receiver keeps popping; a token yields one to four results
// a two-entry command queue parts token intake from result sequencing
// reset: synchronous active-low i_rst_n empties the queue and the output register
`timescale 1ns / 1ps
`default_nettype none
module deflate_fixed_huffman_encoder (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                push,
    output logic                    full,
    input  var dfhe_pkg::t_in_item  i_item,
    output logic                    empty,
    input  var logic                pop,
    output dfhe_pkg::t_out_item     o_result
);
    import dfhe_pkg::*;

    t_cmd    front_cmd;
    t_cmd    q_cmd;
    t_q_req  q_req;
    t_q_stat q_stat;
    logic    back_pop;
    logic    out_valid;

    dfhe_front u_front (
        .i_item (i_item),
        .o_cmd  (front_cmd)
    );

    assign q_req.push = push;
    assign q_req.pop  = back_pop;

    dfhe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (q_req),
        .i_cmd   (front_cmd),
        .o_stat  (q_stat),
        .o_cmd   (q_cmd)
    );

    dfhe_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (q_stat),
        .i_cmd    (q_cmd),
        .i_pop    (pop && out_valid),
        .o_q_pop  (back_pop),
        .o_valid  (out_valid),
        .o_result (o_result)
    );

    assign full  = q_stat.full;
    assign empty = !out_valid;

endmodule
`default_nettype wire

// ===== dv/tb_deflate_fixed_huffman_encoder.sv =====
`timescale 1ns / 1ps
module tb_deflate_fixed_huffman_encoder;
    import dfhe_pkg::*;

    localparam int HOLD_CYCLES = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    t_in_item  i_item = '0;
    logic      full;
    logic      empty;
    t_out_item o_result;

    t_out_item pending_fields [$];
    t_out_item oldest;
    int        errors = 0;
    bit        quiet = 1'b0;
    bit        hold_req = 1'b0;

    int len_base_lut [29];
    int len_xbits_lut [29];
    int dist_base_lut [30];
    int dist_xbits_lut [30];

    deflate_fixed_huffman_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("** deflate_fixed_huffman_encoder: FAILED **");
        $finish;
    end

    // deflate length and distance code bases, built from the extra-bit counts
    initial begin
        len_base_lut[0] = 3;
        for (int i = 0; i < 28; i++) begin
            len_xbits_lut[i] = (i < 8) ? 0 : (i - 4) / 4;
            len_base_lut[i+1] = len_base_lut[i] + (1 << len_xbits_lut[i]);
        end
        len_base_lut[28] = 258;
        len_xbits_lut[28] = 0;
        dist_base_lut[0] = 1;
        for (int i = 0; i < 30; i++) begin
            dist_xbits_lut[i] = (i < 4) ? 0 : (i - 2) / 2;
            if (i < 29) begin
                dist_base_lut[i+1] = dist_base_lut[i] + (1 << dist_xbits_lut[i]);
            end
        end
    end

    function automatic t_out_item make_field(input int bits, input int width, input bit word,
                                             input bit flush, input bit bad);
        t_out_item f;
        f.code_bits     = 13'(bits);
        f.code_width    = 4'(width);
        f.code_word     = word;
        f.flush_request = flush;
        f.bad_token     = bad;
        f.last_of_run   = 1'b0;
        return f;
    endfunction

    // fixed literal/length code, msb first
    function automatic t_out_item huff_ll(input int sym);
        if (sym <= 143) begin
            return make_field(sym + 'h30, 8, 1'b1, 1'b0, 1'b0);
        end else if (sym <= 255) begin
            return make_field(sym - 144 + 'h190, 9, 1'b1, 1'b0, 1'b0);
        end else if (sym <= 279) begin
            return make_field(sym - 256, 7, 1'b1, 1'b0, 1'b0);
        end
        return make_field(sym - 280 + 'hC0, 8, 1'b1, 1'b0, 1'b0);
    endfunction

    function automatic void encode_token(input t_in_item tok);
        t_out_item flds [4];
        t_out_item eob;
        int n;
        int mlen;
        int mdist;
        int li;
        int di;
        n = 0;
        mlen = int'(tok.match_length);
        mdist = int'(tok.match_distance);
        case (tok.kind)
            KIND_START: begin
                flds[0] = make_field(1, 1, 1'b0, 1'b0, 1'b0);
                flds[1] = make_field(1, 2, 1'b0, 1'b0, 1'b0);
                n = 2;
            end
            KIND_LITERAL: begin
                flds[0] = huff_ll(int'(tok.literal));
                n = 1;
            end
            KIND_END: begin
                eob = huff_ll(int'(SYM_END_OF_BLOCK));
                eob.flush_request = 1'b1;
                flds[0] = eob;
                n = 1;
            end
            default: begin
                if (mlen < int'(LEN_MIN) || mlen > int'(LEN_MAX) || mdist < 1
                        || mdist > int'(DIST_MAX)) begin
                    flds[0] = make_field(0, 0, 1'b0, 1'b0, 1'b1);
                    n = 1;
                end else begin
                    li = 0;
                    di = 0;
                    for (int i = 0; i < 29; i++) if (mlen >= len_base_lut[i]) li = i;
                    for (int i = 0; i < 30; i++) if (mdist >= dist_base_lut[i]) di = i;
                    flds[n] = huff_ll(int'(SYM_LEN_FIRST) + li);
                    n++;
                    if (len_xbits_lut[li] != 0) begin
                        flds[n] = make_field(mlen - len_base_lut[li], len_xbits_lut[li],
                                             1'b0, 1'b0, 1'b0);
                        n++;
                    end
                    flds[n] = make_field(di, int'(DIST_CODE_WIDTH), 1'b1, 1'b0, 1'b0);
                    n++;
                    if (dist_xbits_lut[di] != 0) begin
                        flds[n] = make_field(mdist - dist_base_lut[di], dist_xbits_lut[di],
                                             1'b0, 1'b0, 1'b0);
                        n++;
                    end
                end
            end
        endcase
        flds[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) pending_fields.push_back(flds[i]);
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 35);
    endfunction

    function automatic t_in_item make_token(input logic [1:0] kind, input int lit,
                                            input int mlen, input int mdist);
        t_in_item tok;
        tok.kind           = kind;
        tok.literal        = 8'(lit);
        tok.match_length   = 9'(mlen);
        tok.match_distance = 16'(mdist);
        return tok;
    endfunction

    // unused fields carry random junk
    function automatic t_in_item junk_token(input logic [1:0] kind);
        return make_token(kind, $urandom_range(0, 255), $urandom_range(0, 511),
                          $urandom_range(0, 65535));
    endfunction

    function automatic t_in_item good_match();
        int mlen;
        int di;
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) mlen = $urandom_range(3, 10);
        else if (r < 8) mlen = $urandom_range(3, 258);
        else mlen = $urandom_range(227, 258);
        di = $urandom_range(0, 29);
        return make_token(KIND_MATCH, $urandom_range(0, 255), mlen,
                          dist_base_lut[di] + $urandom_range(0, (1 << dist_xbits_lut[di]) - 1));
    endfunction

    function automatic t_in_item bad_match();
        t_in_item tok;
        tok = good_match();
        case ($urandom_range(0, 3))
            0: tok.match_length = 9'($urandom_range(0, 2));
            1: tok.match_length = 9'($urandom_range(259, 511));
            2: tok.match_distance = '0;
            default: tok.match_distance = 16'($urandom_range(32769, 65535));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            tok.match_length = 9'($urandom_range(0, 511));
        end
        return tok;
    endfunction

    task automatic send_token(input t_in_item tok);
        int gap;
        push <= 1'b1;
        i_item <= tok;
        do @(posedge i_clk); while (full);
        encode_token(tok);
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_fields.size() == 0) begin
                $error("unexpected transaction: code_bits %0d code_width %0d",
                       o_result.code_bits, o_result.code_width);
                errors++;
            end else begin
                oldest = pending_fields.pop_front();
                check_field("code_bits", oldest.code_bits, o_result.code_bits);
                check_field("code_width", oldest.code_width, o_result.code_width);
                check_field("code_word", oldest.code_word, o_result.code_word);
                check_field("flush_request", oldest.flush_request, o_result.flush_request);
                check_field("bad_token", oldest.bad_token, o_result.bad_token);
                check_field("last_of_run", oldest.last_of_run, o_result.last_of_run);
            end
        end
    end

    initial begin : pop_driver
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    pop <= 1'b1;
                end else begin
                    pop <= 1'b0;
                    repeat (gap - 1) @(posedge i_clk);
                end
            end
        end
    end

    task automatic test_block_framing();
        send_token(junk_token(KIND_START));
        send_token(junk_token(KIND_END));
    endtask

    task automatic test_literal_codes();
        int lits [4] = '{0, 143, 144, 255};
        foreach (lits[i]) send_token(make_token(KIND_LITERAL, lits[i], $urandom_range(0, 511),
                                                $urandom_range(0, 65535)));
    endtask

    task automatic test_match_codes();
        int lens [6] = '{3, 10, 11, 257, 258, 18};
        int dists [6] = '{1, 4, 5, 32768, 24577, 7};
        foreach (lens[i]) send_token(make_token(KIND_MATCH, $urandom_range(0, 255),
                                                lens[i], dists[i]));
    endtask

    task automatic test_bad_tokens();
        int lens [6] = '{2, 259, 3, 3, 511, 0};
        int dists [6] = '{1, 1, 0, 32769, 65535, 0};
        foreach (lens[i]) send_token(make_token(KIND_MATCH, $urandom_range(0, 255),
                                                lens[i], dists[i]));
    endtask

    // receiver stalls while the sender keeps offering back to back
    task automatic test_back_pressure();
        hold_req = 1'b1;
        quiet = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_token(($urandom_range(0, 1) == 0) ? good_match() : junk_token(KIND_LITERAL));
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_blocks();
        int sent;
        int body;
        int r;
        sent = 0;
        while (sent < 330) begin
            quiet = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0) begin
                body = $urandom_range(1, 6);
                repeat (body) send_token(junk_token(2'($urandom_range(0, 3))));
                sent += body;
            end else begin
                send_token(junk_token(KIND_START));
                body = $urandom_range(1, 12);
                repeat (body) begin
                    r = $urandom_range(0, 99);
                    if (r < 50) send_token(junk_token(KIND_LITERAL));
                    else if (r < 90) send_token(good_match());
                    else send_token(bad_match());
                end
                send_token(junk_token(KIND_END));
                sent += body + 2;
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_block_framing();
        test_literal_codes();
        test_match_codes();
        test_bad_tokens();
        test_back_pressure();
        test_random_blocks();
        push <= 1'b0;
        quiet = 1'b1;
        while (pending_fields.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("** deflate_fixed_huffman_encoder: PASSED **");
        end else begin
            $display("** deflate_fixed_huffman_encoder: FAILED **");
        end
        $finish;
    end

endmodule
